@@ rtl/core/pca_pkg.sv @@
// ----------------------------------------------------------------------------
// pca_pkg
// Types, codes and defaults shared by the preemptive channel allocator.
// ----------------------------------------------------------------------------
package pca_pkg;

   // Defaults for the top-level parameters.
   localparam int NUM_CHANNELS_DEF = 16;
   localparam int ID_BITS_DEF      = 16;

   // Fixed field widths of the request and response words.
   localparam int FUNC_BITS   = 3;
   localparam int CHAN_BITS   = 8;
   localparam int UID_BITS    = 16;
   localparam int STATUS_BITS = 2;
   localparam int CST_BITS    = 2;
   localparam int COUNT_BITS  = 9;

   // Configuration port.
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 9;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MODE     = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RESERVED = 1'b1;
   localparam logic [CSR_DATA_BITS-1:0] RESERVED_RST = 9'd4;

   // Request function codes.
   typedef enum logic [FUNC_BITS-1:0] {
      FN_ASSIGN      = 3'd0,
      FN_SEC_RELEASE = 3'd1,
      FN_PRI_OCCUPY  = 3'd2,
      FN_PRI_RELEASE = 3'd3,
      FN_QUERY       = 3'd4
   } func_type;

   // Response status codes.
   typedef enum logic [STATUS_BITS-1:0] {
      RS_OK      = 2'd0,
      RS_RANGE   = 2'd1,
      RS_NOFREE  = 2'd2,
      RS_NOTHELD = 2'd3
   } status_type;

   // Channel state codes as reported in a response.
   typedef enum logic [CST_BITS-1:0] {
      CS_FREE = 2'd0,
      CS_PRIM = 2'd1,
      CS_SEC  = 2'd2
   } chst_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SRCH,
      FSM_EXEC
   } fsm_type;

endpackage

@@ rtl/core/pca_intf.sv @@
// ----------------------------------------------------------------------------
// pca_intf
// Valid/ready channels carrying request and response words of the allocator.
// ----------------------------------------------------------------------------
interface pca_req_if;
   logic                          valid;
   logic                          ready;
   logic [pca_pkg::FUNC_BITS-1:0] func;
   logic [pca_pkg::CHAN_BITS-1:0] channel;
   logic [pca_pkg::UID_BITS-1:0]  user_id;

   modport source (output valid, func, channel, user_id, input ready);
   modport sink   (input valid, func, channel, user_id, output ready);
endinterface

interface pca_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [pca_pkg::STATUS_BITS-1:0] status;
   logic [pca_pkg::CHAN_BITS-1:0]   result_channel;
   logic [pca_pkg::CST_BITS-1:0]    channel_state;
   logic [pca_pkg::UID_BITS-1:0]    occupant_id;
   logic                            ousted_valid;
   logic [pca_pkg::UID_BITS-1:0]    ousted_id;
   logic [pca_pkg::COUNT_BITS-1:0]  free_count;

   modport source (output valid, status, result_channel, channel_state, occupant_id,
                   ousted_valid, ousted_id, free_count, input ready);
   modport sink   (input valid, status, result_channel, channel_state, occupant_id,
                   ousted_valid, ousted_id, free_count, output ready);
endinterface

@@ rtl/core/pca_ram.sv @@
// ----------------------------------------------------------------------------
// pca_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pca_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage array and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/preemptive_channel_allocator.sv @@
// ----------------------------------------------------------------------------
// preemptive_channel_allocator
// Channel table shared by primary and preempted secondary users.
//
//   channel   direction  word contents
//   req_ch    in         func, channel, user_id
//   rsp_ch    out        status, result_channel, channel_state, occupant_id,
//                        ousted_valid, ousted_id, free_count
//   csr_*     in         scenario_mode (index 0), reserved_channels (index 1)
//
// Each request word passes three steps: accept with the owner RAM read, a
// registered per-group first-free search, then execute and write back. The
// next word is accepted the cycle after write back.
// A response waits in the output register; only the execute step holds while
// that register is still full.
// Synchronous reset marks every channel free directly; no clearing pass.
// ----------------------------------------------------------------------------
module preemptive_channel_allocator #(
   parameter int NUM_CHANNELS = pca_pkg::NUM_CHANNELS_DEF,
   parameter int ID_BITS      = pca_pkg::ID_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   pca_req_if.sink                            req_ch,
   pca_rsp_if.source                          rsp_ch,
   input  logic                               csr_we,
   input  logic [pca_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [pca_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int CH_BITS  = $clog2(NUM_CHANNELS);
   localparam int CNT_BITS = $clog2(NUM_CHANNELS + 1);
   localparam int GRP      = (NUM_CHANNELS < 16) ? NUM_CHANNELS : 16;
   localparam int NGRP     = (NUM_CHANNELS + GRP - 1) / GRP;
   localparam int GB       = $clog2(GRP);
   localparam int PADN     = NGRP * GRP;
   localparam int RAM_W    = ID_BITS + 1;

   // Configuration registers.
   logic                               mode_ff;
   logic [pca_pkg::CSR_DATA_BITS-1:0]  reserved_ff;

   // Sequencer and captured request.
   pca_pkg::fsm_type                   state_ff, state_in;
   logic [pca_pkg::FUNC_BITS-1:0]      func_ff;
   logic [pca_pkg::CHAN_BITS-1:0]      chan_ff;
   logic [ID_BITS-1:0]                 uid_ff;

   // Channel occupancy flags and free count.
   logic [NUM_CHANNELS-1:0]            free_ff, free_in;
   logic [CNT_BITS-1:0]                cnt_ff, cnt_in;

   // Per-group search results.
   logic [NGRP-1:0]                    up_hit_ff, lo_hit_ff;
   logic [GB-1:0]                      up_off_ff [NGRP];
   logic [GB-1:0]                      lo_off_ff [NGRP];
   logic [NGRP-1:0]                    up_hit_in, lo_hit_in;
   logic [GB-1:0]                      up_off_in [NGRP];
   logic [GB-1:0]                      lo_off_in [NGRP];
   logic [PADN-1:0]                    up_vec, lo_vec;

   // Response register.
   logic                               rsp_valid_ff;
   logic [pca_pkg::STATUS_BITS-1:0]    rsp_status_ff, rsp_status_in;
   logic [pca_pkg::CHAN_BITS-1:0]      rsp_chan_ff, rsp_chan_in;
   logic [pca_pkg::CST_BITS-1:0]       rsp_cst_ff, rsp_cst_in;
   logic [pca_pkg::UID_BITS-1:0]       rsp_occ_ff, rsp_occ_in;
   logic                               rsp_ov_ff, rsp_ov_in;
   logic [pca_pkg::UID_BITS-1:0]       rsp_oid_ff, rsp_oid_in;

   // Owner RAM: {secondary flag, owner id}, meaningful only while held.
   logic                               ram_we, ram_re;
   logic [CH_BITS-1:0]                 ram_waddr;
   logic [RAM_W-1:0]                   ram_wdata, ram_rdata;

   // Execute step signals.
   logic                               fire, accept;
   logic [CH_BITS-1:0]                 ch_idx;
   logic                               in_range;
   logic                               cur_free, cur_sec, cur_prim;
   logic [ID_BITS-1:0]                 cur_owner;
   logic [pca_pkg::CST_BITS-1:0]       cur_code;
   logic [pca_pkg::UID_BITS-1:0]       cur_occ;
   logic                               found_up, found_lo;
   logic [CH_BITS-1:0]                 pick_up, pick_lo, pick;

   pca_ram #(
      .WIDTH (RAM_W),
      .DEPTH (NUM_CHANNELS)
   ) u_owner_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (CH_BITS'(req_ch.channel)),
      .rd_data (ram_rdata)
   );

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= 1'b0;
         reserved_ff <= pca_pkg::RESERVED_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            pca_pkg::CSR_MODE:     mode_ff     <= csr_wdata[0];
            pca_pkg::CSR_RESERVED: reserved_ff <= csr_wdata;
            default:               mode_ff     <= mode_ff;
         endcase
      end
   end

   // Sequencer: next state and handshake outputs.
   assign fire = (state_ff == pca_pkg::FSM_EXEC) && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      state_in     = state_ff;
      req_ch.ready = 1'b0;
      unique case (state_ff)
         pca_pkg::FSM_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               state_in = pca_pkg::FSM_SRCH;
            end
         end
         pca_pkg::FSM_SRCH: begin
            state_in = pca_pkg::FSM_EXEC;
         end
         pca_pkg::FSM_EXEC: begin
            if (fire) begin
               state_in = pca_pkg::FSM_IDLE;
            end
         end
         default: begin
            state_in = pca_pkg::FSM_IDLE;
         end
      endcase
   end

   assign accept = req_ch.valid && req_ch.ready;
   assign ram_re = accept;

   // Free channels split into the upper range and, in mode 1, the lower range.
   always_comb begin
      up_vec = '0;
      lo_vec = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         up_vec[i] = free_ff[i] && (9'(i) >= reserved_ff);
         lo_vec[i] = free_ff[i] && (9'(i) < reserved_ff) && mode_ff;
      end
   end

   // First free channel inside each group.
   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         up_hit_in[g] = 1'b0;
         lo_hit_in[g] = 1'b0;
         up_off_in[g] = '0;
         lo_off_in[g] = '0;
         for (int k = GRP - 1; k >= 0; k--) begin
            if (up_vec[g * GRP + k]) begin
               up_hit_in[g] = 1'b1;
               up_off_in[g] = GB'(k);
            end
            if (lo_vec[g * GRP + k]) begin
               lo_hit_in[g] = 1'b1;
               lo_off_in[g] = GB'(k);
            end
         end
      end
   end

   // First group with a hit gives the channel picked by an assign.
   always_comb begin
      found_up = 1'b0;
      found_lo = 1'b0;
      pick_up  = '0;
      pick_lo  = '0;
      for (int g = NGRP - 1; g >= 0; g--) begin
         if (up_hit_ff[g]) begin
            found_up = 1'b1;
            pick_up  = CH_BITS'(g * GRP + int'(up_off_ff[g]));
         end
         if (lo_hit_ff[g]) begin
            found_lo = 1'b1;
            pick_lo  = CH_BITS'(g * GRP + int'(lo_off_ff[g]));
         end
      end
      pick = found_up ? pick_up : pick_lo;
   end

   // State of the addressed channel, from the flags and the owner RAM.
   assign ch_idx    = CH_BITS'(chan_ff);
   assign in_range  = {1'b0, chan_ff} < 9'(NUM_CHANNELS);
   assign cur_free  = free_ff[ch_idx];
   assign cur_sec   = !cur_free && ram_rdata[ID_BITS];
   assign cur_prim  = !cur_free && !ram_rdata[ID_BITS];
   assign cur_owner = ram_rdata[ID_BITS-1:0];
   assign cur_code  = cur_free ? pca_pkg::CS_FREE :
                      (cur_sec ? pca_pkg::CS_SEC : pca_pkg::CS_PRIM);
   assign cur_occ   = cur_sec ? pca_pkg::UID_BITS'(cur_owner) : '0;

   // Execute: decode the function, form the response and the write back.
   always_comb begin
      free_in       = free_ff;
      cnt_in        = cnt_ff;
      ram_we        = 1'b0;
      ram_waddr     = ch_idx;
      ram_wdata     = '0;
      rsp_status_in = pca_pkg::RS_OK;
      rsp_chan_in   = chan_ff;
      rsp_cst_in    = pca_pkg::CS_FREE;
      rsp_occ_in    = '0;
      rsp_ov_in     = 1'b0;
      rsp_oid_in    = '0;
      if (func_ff == pca_pkg::FN_ASSIGN) begin
         if (found_up || found_lo) begin
            free_in[pick] = 1'b0;
            cnt_in        = cnt_ff - CNT_BITS'(1);
            ram_we        = fire;
            ram_waddr     = pick;
            ram_wdata     = {1'b1, uid_ff};
            rsp_chan_in   = pca_pkg::CHAN_BITS'(pick);
            rsp_cst_in    = pca_pkg::CS_SEC;
            rsp_occ_in    = pca_pkg::UID_BITS'(uid_ff);
         end else begin
            rsp_status_in = pca_pkg::RS_NOFREE;
            rsp_chan_in   = '0;
         end
      end else if (!in_range) begin
         rsp_status_in = pca_pkg::RS_RANGE;
      end else begin
         unique case (func_ff)
            pca_pkg::FN_SEC_RELEASE: begin
               if (cur_sec && (cur_owner == uid_ff)) begin
                  free_in[ch_idx] = 1'b1;
                  cnt_in          = cnt_ff + CNT_BITS'(1);
               end else begin
                  rsp_status_in = pca_pkg::RS_NOTHELD;
                  rsp_cst_in    = cur_code;
                  rsp_occ_in    = cur_occ;
               end
            end
            pca_pkg::FN_PRI_OCCUPY: begin
               rsp_cst_in = pca_pkg::CS_PRIM;
               if (!cur_prim) begin
                  ram_we    = fire;
                  ram_wdata = '0;
               end
               if (cur_sec) begin
                  rsp_ov_in  = 1'b1;
                  rsp_oid_in = pca_pkg::UID_BITS'(cur_owner);
               end
               if (cur_free) begin
                  free_in[ch_idx] = 1'b0;
                  cnt_in          = cnt_ff - CNT_BITS'(1);
               end
            end
            pca_pkg::FN_PRI_RELEASE: begin
               if (cur_prim) begin
                  free_in[ch_idx] = 1'b1;
                  cnt_in          = cnt_ff + CNT_BITS'(1);
               end else begin
                  rsp_status_in = pca_pkg::RS_NOTHELD;
                  rsp_cst_in    = cur_code;
                  rsp_occ_in    = cur_occ;
               end
            end
            default: begin
               rsp_cst_in = cur_code;
               rsp_occ_in = cur_occ;
            end
         endcase
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pca_pkg::FSM_IDLE;
         free_ff      <= '1;
         cnt_ff       <= CNT_BITS'(NUM_CHANNELS);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (fire) begin
            free_ff      <= free_in;
            cnt_ff       <= cnt_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Request capture, search results and response payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_ch.func;
         chan_ff <= req_ch.channel;
         uid_ff  <= ID_BITS'(req_ch.user_id);
      end
      if (state_ff == pca_pkg::FSM_SRCH) begin
         up_hit_ff <= up_hit_in;
         lo_hit_ff <= lo_hit_in;
         up_off_ff <= up_off_in;
         lo_off_ff <= lo_off_in;
      end
      if (fire) begin
         rsp_status_ff <= rsp_status_in;
         rsp_chan_ff   <= rsp_chan_in;
         rsp_cst_ff    <= rsp_cst_in;
         rsp_occ_ff    <= rsp_occ_in;
         rsp_ov_ff     <= rsp_ov_in;
         rsp_oid_ff    <= rsp_oid_in;
      end
   end

   // Response outputs.
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.result_channel = rsp_chan_ff;
   assign rsp_ch.channel_state  = rsp_cst_ff;
   assign rsp_ch.occupant_id    = rsp_occ_ff;
   assign rsp_ch.ousted_valid   = rsp_ov_ff;
   assign rsp_ch.ousted_id      = rsp_oid_ff;
   assign rsp_ch.free_count     = pca_pkg::COUNT_BITS'(cnt_ff);

   // The free count always matches the number of free flags.
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      int'(cnt_ff) == $countones(free_ff))
      else $error("free count differs from free flags");

   // A blocked response holds the execute step, so nothing is applied twice.
   a_exec_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pca_pkg::FSM_EXEC && rsp_valid_ff && !rsp_ch.ready)
      |=> (state_ff == pca_pkg::FSM_EXEC))
      else $error("execute step left while response blocked");

   // The owner RAM is written only in the execute step that issues a response.
   a_write_on_fire: assert property (@(posedge clock) disable iff (reset)
      ram_we |=> rsp_valid_ff)
      else $error("owner RAM written without a response");

endmodule
